[hdl/lcdc_pkg.sv]
// Package for the LCD controller register block: types, register offsets and mask helper.
package lcdc_pkg;

    // Request kinds carried by one input beat
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_DESC  = 2'd3
    } lcdc_req_t;

    // Frame sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_SOF  = 2'd2,
        PH_EOF  = 2'd3
    } lcdc_phase_t;

    // Register word offsets
    localparam logic [9:0] REG_CTRL0  = 10'd0;
    localparam logic [9:0] REG_CTRL1  = 10'd1;
    localparam logic [9:0] REG_CTRL2  = 10'd2;
    localparam logic [9:0] REG_CTRL3  = 10'd3;
    localparam logic [9:0] REG_BRANCH0 = 10'd8;
    localparam logic [9:0] REG_BRANCH1 = 10'd9;
    localparam logic [9:0] REG_STATUS = 10'd14;
    localparam logic [9:0] REG_MISC0  = 10'd15;
    localparam logic [9:0] REG_MISC1  = 10'd16;
    localparam logic [9:0] REG_MISC2  = 10'd17;
    localparam logic [9:0] REG_DESC0  = 10'd128;
    localparam logic [9:0] REG_DESC1  = 10'd129;
    localparam logic [9:0] REG_DESC2  = 10'd130;
    localparam logic [9:0] REG_DESC3  = 10'd131;
    localparam logic [9:0] REG_CH1NEXT = 10'd132;

    // Interrupt mask and status bits
    localparam logic [15:0] MASK_BASE    = 16'h7C8E;
    localparam logic [31:0] ST_DISABLED  = 32'h0000_0080;
    localparam logic [31:0] ST_BRANCH    = 32'h0000_0200;
    localparam logic [31:0] ST_SOF       = 32'h0000_0002;
    localparam logic [31:0] ST_EOF       = 32'h0000_0100;
    localparam logic [31:0] CMD_SOF_EN   = 32'h0040_0000;
    localparam logic [31:0] CMD_EOF_EN   = 32'h0020_0000;
    localparam logic [31:0] DESC_ALIGN   = 32'hFFFF_FFF0;

    // One input beat
    typedef struct packed {
        lcdc_req_t   req_type;
        logic [9:0]  reg_index;
        logic        word_access;
        logic [31:0] write_data;
        logic [31:0] desc_next;
        logic [31:0] desc_source;
        logic [31:0] desc_ident;
        logic [31:0] desc_command;
    } lcdc_item_t;

    // One result beat
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
        logic        fetch_request;
        logic [31:0] fetch_address;
    } lcdc_result_t;

    // Interrupt mask implied by a control zero value
    function automatic logic [15:0] lcdc_mask(input logic [31:0] v);
        logic [15:0] m;
        m = MASK_BASE;
        if (v[21]) m = m | 16'h0040;
        if (v[20]) m = m | 16'h0200;
        if (v[10]) m = m | 16'h0001;
        if (v[6])  m = m | 16'h0080;
        if (v[5])  m = m | 16'h0030;
        if (v[4])  m = m | 16'h0002;
        return m;
    endfunction

endpackage

[hdl/lcdc_in_stage.sv]
// Input register stage: captures one beat and holds it until the core takes it.
module lcdc_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lcdc_pkg::lcdc_item_t item,
    input  logic                 advance,
    output logic                 item_valid,
    output lcdc_pkg::lcdc_item_t item_held
);

    logic                 valid_reg;
    lcdc_pkg::lcdc_item_t item_reg;
    logic                 accept;

    // Stall only while a held beat cannot move on
    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item_held  = item_reg;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule

[hdl/lcdc_core.sv]
// Register file, interrupt logic and frame sequencer; computes one result per beat.
module lcdc_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  lcdc_pkg::lcdc_item_t   item,
    output lcdc_pkg::lcdc_result_t result
);

    logic [31:0] ctrl0_reg, ctrl0_next;
    logic [31:0] ctrl1_reg, ctrl1_next;
    logic [31:0] ctrl2_reg, ctrl2_next;
    logic [31:0] ctrl3_reg, ctrl3_next;
    logic [31:0] branch0_reg, branch0_next;
    logic [31:0] branch1_reg, branch1_next;
    logic [31:0] status_reg, status_next;
    logic [31:0] misc_reg [3];
    logic [31:0] misc_next [3];
    logic [31:0] desc_reg [4];
    logic [31:0] desc_next [4];
    logic [31:0] ch1next_reg, ch1next_next;
    logic [15:0] mask_reg, mask_next;
    logic        irq_reg, irq_next;
    logic        toggled_reg, toggled_next;
    lcdc_pkg::lcdc_phase_t phase_reg, phase_next;

    logic [31:0] rd_value;

    // Decode register reads
    always_comb
    begin
        unique case (item.reg_index)
            lcdc_pkg::REG_CTRL0:   rd_value = ctrl0_reg;
            lcdc_pkg::REG_CTRL1:   rd_value = ctrl1_reg;
            lcdc_pkg::REG_CTRL2:   rd_value = ctrl2_reg;
            lcdc_pkg::REG_CTRL3:   rd_value = ctrl3_reg;
            lcdc_pkg::REG_BRANCH0: rd_value = branch0_reg;
            lcdc_pkg::REG_BRANCH1: rd_value = branch1_reg;
            lcdc_pkg::REG_STATUS:  rd_value = status_reg;
            lcdc_pkg::REG_MISC0:   rd_value = misc_reg[0];
            lcdc_pkg::REG_MISC1:   rd_value = misc_reg[1];
            lcdc_pkg::REG_MISC2:   rd_value = misc_reg[2];
            lcdc_pkg::REG_DESC0:   rd_value = desc_reg[0];
            lcdc_pkg::REG_DESC1:   rd_value = desc_reg[1];
            lcdc_pkg::REG_DESC2:   rd_value = desc_reg[2];
            lcdc_pkg::REG_DESC3:   rd_value = desc_reg[3];
            lcdc_pkg::REG_CH1NEXT: rd_value = ch1next_reg;
            default:               rd_value = 32'd0;
        endcase
    end

    // Next state and result for the beat in the input register
    always_comb
    begin
        ctrl0_next   = ctrl0_reg;
        ctrl1_next   = ctrl1_reg;
        ctrl2_next   = ctrl2_reg;
        ctrl3_next   = ctrl3_reg;
        branch0_next = branch0_reg;
        branch1_next = branch1_reg;
        status_next  = status_reg;
        misc_next    = misc_reg;
        desc_next    = desc_reg;
        ch1next_next = ch1next_reg;
        mask_next    = mask_reg;
        irq_next     = irq_reg;
        toggled_next = toggled_reg;
        phase_next   = phase_reg;
        result       = '0;
        result.irq_level = irq_reg;

        if (fire)
        begin
            unique case (item.req_type)
                lcdc_pkg::REQ_READ:
                begin
                    if (item.word_access)
                    begin
                        result.read_data = rd_value;
                    end
                end
                lcdc_pkg::REQ_WRITE:
                begin
                    if (item.word_access)
                    begin
                        unique case (item.reg_index)
                            lcdc_pkg::REG_CTRL0:
                            begin
                                if (ctrl0_reg[0] != item.write_data[0])
                                begin
                                    toggled_next = 1'b1;
                                end
                                ctrl0_next = item.write_data;
                                mask_next  = lcdc_pkg::lcdc_mask(item.write_data);
                                irq_next   = |(status_reg[15:0] & mask_next);
                            end
                            lcdc_pkg::REG_CTRL1:   ctrl1_next = item.write_data;
                            lcdc_pkg::REG_CTRL2:   ctrl2_next = item.write_data;
                            lcdc_pkg::REG_CTRL3:   ctrl3_next = item.write_data;
                            lcdc_pkg::REG_BRANCH0: branch0_next = item.write_data;
                            lcdc_pkg::REG_BRANCH1: branch1_next = item.write_data;
                            lcdc_pkg::REG_STATUS:
                            begin
                                status_next = status_reg & ~item.write_data;
                                irq_next    = |(status_next[15:0] & mask_reg);
                            end
                            lcdc_pkg::REG_MISC0:   misc_next[0] = item.write_data;
                            lcdc_pkg::REG_MISC1:   misc_next[1] = item.write_data;
                            lcdc_pkg::REG_MISC2:   misc_next[2] = item.write_data;
                            lcdc_pkg::REG_DESC0:   desc_next[0] = item.write_data;
                            lcdc_pkg::REG_CH1NEXT: ch1next_next = item.write_data;
                            default:
                            begin
                            end
                        endcase
                    end
                end
                lcdc_pkg::REQ_TICK:
                begin
                    // Handle an enable change first
                    if (toggled_reg)
                    begin
                        if (!ctrl0_reg[0])
                        begin
                            status_next = status_next | lcdc_pkg::ST_DISABLED;
                            phase_next  = lcdc_pkg::PH_IDLE;
                        end
                        toggled_next = 1'b0;
                    end
                    // Advance the frame sequence while enabled
                    if (ctrl0_reg[0])
                    begin
                        unique case (phase_reg)
                            lcdc_pkg::PH_IDLE:
                            begin
                                if (branch0_reg[0])
                                begin
                                    branch0_next = {branch0_reg[31:1], 1'b0};
                                    if (branch0_reg[1])
                                    begin
                                        status_next = status_next | lcdc_pkg::ST_BRANCH;
                                    end
                                    result.fetch_address = branch0_reg & lcdc_pkg::DESC_ALIGN;
                                end
                                else
                                begin
                                    result.fetch_address = desc_reg[0];
                                end
                                result.fetch_request = 1'b1;
                                phase_next = lcdc_pkg::PH_WAIT;
                            end
                            lcdc_pkg::PH_SOF:
                            begin
                                if ((desc_reg[3] & lcdc_pkg::CMD_SOF_EN) != 32'd0)
                                begin
                                    status_next = status_next | lcdc_pkg::ST_SOF;
                                end
                                phase_next = lcdc_pkg::PH_EOF;
                            end
                            lcdc_pkg::PH_EOF:
                            begin
                                if ((desc_reg[3] & lcdc_pkg::CMD_EOF_EN) != 32'd0)
                                begin
                                    status_next = status_next | lcdc_pkg::ST_EOF;
                                end
                                phase_next = lcdc_pkg::PH_IDLE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    irq_next = |(status_next[15:0] & mask_reg);
                end
                lcdc_pkg::REQ_DESC:
                begin
                    // Take descriptor words only while waiting for them
                    if (phase_reg == lcdc_pkg::PH_WAIT)
                    begin
                        desc_next[0] = item.desc_next;
                        desc_next[1] = item.desc_source;
                        desc_next[2] = item.desc_ident;
                        desc_next[3] = item.desc_command;
                        phase_next   = lcdc_pkg::PH_SOF;
                    end
                end
                default:
                begin
                end
            endcase
            result.irq_level = irq_next;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl0_reg   <= '0;
            ctrl1_reg   <= '0;
            ctrl2_reg   <= '0;
            ctrl3_reg   <= '0;
            branch0_reg <= '0;
            branch1_reg <= '0;
            status_reg  <= '0;
            misc_reg    <= '{default: '0};
            desc_reg    <= '{default: '0};
            ch1next_reg <= '0;
            mask_reg    <= lcdc_pkg::MASK_BASE;
            irq_reg     <= 1'b0;
            toggled_reg <= 1'b0;
            phase_reg   <= lcdc_pkg::PH_IDLE;
        end
        else
        begin
            ctrl0_reg   <= ctrl0_next;
            ctrl1_reg   <= ctrl1_next;
            ctrl2_reg   <= ctrl2_next;
            ctrl3_reg   <= ctrl3_next;
            branch0_reg <= branch0_next;
            branch1_reg <= branch1_next;
            status_reg  <= status_next;
            misc_reg    <= misc_next;
            desc_reg    <= desc_next;
            ch1next_reg <= ch1next_next;
            mask_reg    <= mask_next;
            irq_reg     <= irq_next;
            toggled_reg <= toggled_next;
            phase_reg   <= phase_next;
        end
    end

    // The pending flag always tracks status under mask
    a_irq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        irq_reg == (|(status_reg[15:0] & mask_reg)))
        else $error("pending flag out of step with status and mask");

    // A fetch request moves the sequencer to wait for the descriptor
    a_fetch_waits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.fetch_request |=> phase_reg == lcdc_pkg::PH_WAIT)
        else $error("fetch request without entering wait phase");

    // No fetch while disabled
    a_no_fetch_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.req_type == lcdc_pkg::REQ_TICK && !ctrl0_reg[0]
        |-> !result.fetch_request)
        else $error("fetch requested while disabled");

    // Stray descriptor words leave the descriptor alone
    a_stray_desc: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.req_type == lcdc_pkg::REQ_DESC && phase_reg != lcdc_pkg::PH_WAIT
        |=> $stable(desc_reg[3]) && $stable(desc_reg[1]))
        else $error("descriptor changed outside wait phase");

endmodule

[hdl/lcdc_out_stage.sv]
// Output register stage: holds one result beat until the receiver takes it.
module lcdc_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  lcdc_pkg::lcdc_result_t result,
    output logic                   advance,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            read_data,
    output logic                   irq_level,
    output logic                   fetch_request,
    output logic [31:0]            fetch_address
);

    logic                   valid_reg;
    lcdc_pkg::lcdc_result_t result_reg;

    // Room for a new result when empty or draining this cycle
    assign advance       = !valid_reg || !out_stall;
    assign out_valid     = valid_reg;
    assign read_data     = result_reg.read_data;
    assign irq_level     = result_reg.irq_level;
    assign fetch_request = result_reg.fetch_request;
    assign fetch_address = result_reg.fetch_address;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Load result
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

endmodule

[hdl/lcd_controller_registers_and_frame_fsm_top.sv]
// Top level of the LCD controller register block and frame sequencer.
// Beats go from the input register through one pass of register logic to the output register.
// One beat per cycle while the output is not stalled.
// Backpressure on the output stalls the input only once both registers hold a beat.
// Reset (rst_n low, asynchronous): registers clear, interrupt mask returns to 0x7C8E,
// the sequencer returns to idle and both stages empty.
module lcd_controller_registers_and_frame_fsm_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [9:0]  reg_index,
    input  logic        word_access,
    input  logic [31:0] write_data,
    input  logic [31:0] desc_next,
    input  logic [31:0] desc_source,
    input  logic [31:0] desc_ident,
    input  logic [31:0] desc_command,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        irq_level,
    output logic        fetch_request,
    output logic [31:0] fetch_address
);

    lcdc_pkg::lcdc_item_t   item_in;
    lcdc_pkg::lcdc_item_t   item_held;
    lcdc_pkg::lcdc_result_t result;
    logic                   item_valid;
    logic                   advance;
    logic                   fire;

    // Pack the input beat
    always_comb
    begin
        item_in.req_type     = lcdc_pkg::lcdc_req_t'(req_type);
        item_in.reg_index    = reg_index;
        item_in.word_access  = word_access;
        item_in.write_data   = write_data;
        item_in.desc_next    = desc_next;
        item_in.desc_source  = desc_source;
        item_in.desc_ident   = desc_ident;
        item_in.desc_command = desc_command;
    end

    assign fire = item_valid && advance;

    lcdc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item       (item_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item_held  (item_held)
    );

    lcdc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_held),
        .result (result)
    );

    lcdc_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .result        (result),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .irq_level     (irq_level),
        .fetch_request (fetch_request),
        .fetch_address (fetch_address)
    );

endmodule

[test/testbench.sv]
// Testbench for the LCD controller register block and its descriptor frame sequencer.
`timescale 1ns / 100ps

module testbench;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BEATS = 330;

    // Offsets outside the register map
    localparam logic [9:0] REG_UNMAPPED_LO = 10'd4;
    localparam logic [9:0] REG_UNMAPPED_HI = 10'd133;
    localparam logic [9:0] REG_LAST = 10'd1023;

    // Control zero bits that matter to the sequencer and the mask
    localparam logic [31:0] CTRL_ENABLE = 32'h0000_0001;
    localparam logic [31:0] CTRL_ALL_IRQ = 32'h0030_0470;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [9:0]  reg_index;
    logic        word_access;
    logic [31:0] write_data;
    logic [31:0] desc_next;
    logic [31:0] desc_source;
    logic [31:0] desc_ident;
    logic [31:0] desc_command;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic        irq_level;
    logic        fetch_request;
    logic [31:0] fetch_address;

    int sender_idle_pct;
    int receiver_idle_pct;
    int failures = 0;
    int cycle_count = 0;
    int beats_sent;

    // Replies predicted for accepted beats, oldest first
    lcdc_pkg::lcdc_result_t reply_q[$];
    lcdc_pkg::lcdc_result_t head_reply;

    // Shadow copy of the block's registers and sequencer
    logic [31:0] sh_ctrl [4];
    logic [31:0] sh_branch0;
    logic [31:0] sh_branch1;
    logic [31:0] sh_status;
    logic [31:0] sh_misc [3];
    logic [31:0] sh_desc [4];
    logic [31:0] sh_ch1next;
    logic [15:0] sh_mask;
    logic        sh_irq;
    logic        sh_toggled;
    lcdc_pkg::lcdc_phase_t sh_phase;

    lcd_controller_registers_and_frame_fsm_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .reg_index     (reg_index),
        .word_access   (word_access),
        .write_data    (write_data),
        .desc_next     (desc_next),
        .desc_source   (desc_source),
        .desc_ident    (desc_ident),
        .desc_command  (desc_command),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .irq_level     (irq_level),
        .fetch_request (fetch_request),
        .fetch_address (fetch_address)
    );

    always #HALF_PERIOD clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < receiver_idle_pct);
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_q.size() == 0)
            begin
                $error("result beat with no prediction pending");
                failures++;
            end
            else
            begin
                head_reply = reply_q.pop_front();
                if (read_data !== head_reply.read_data)
                begin
                    $error("read_data: expected %h, got %h", head_reply.read_data, read_data);
                    failures++;
                end
                if (irq_level !== head_reply.irq_level)
                begin
                    $error("irq_level: expected %b, got %b", head_reply.irq_level, irq_level);
                    failures++;
                end
                if (fetch_request !== head_reply.fetch_request)
                begin
                    $error("fetch_request: expected %b, got %b",
                           head_reply.fetch_request, fetch_request);
                    failures++;
                end
                if (fetch_address !== head_reply.fetch_address)
                begin
                    $error("fetch_address: expected %h, got %h",
                           head_reply.fetch_address, fetch_address);
                    failures++;
                end
            end
        end
    end

    function automatic void clear_shadow();
        sh_ctrl = '{default: '0};
        sh_misc = '{default: '0};
        sh_desc = '{default: '0};
        sh_branch0 = '0;
        sh_branch1 = '0;
        sh_status = '0;
        sh_ch1next = '0;
        sh_mask = lcdc_pkg::MASK_BASE;
        sh_irq = 1'b0;
        sh_toggled = 1'b0;
        sh_phase = lcdc_pkg::PH_IDLE;
    endfunction

    function automatic void refresh_irq();
        sh_irq = |(sh_status[15:0] & sh_mask);
    endfunction

    // Control zero enables extra interrupt sources on top of the base mask
    function automatic logic [15:0] irq_mask_for(input logic [31:0] c0);
        logic [15:0] m;
        m = lcdc_pkg::MASK_BASE;
        m[0] = m[0] | c0[10];
        m[1] = m[1] | c0[4];
        m[4] = m[4] | c0[5];
        m[5] = m[5] | c0[5];
        m[6] = m[6] | c0[21];
        m[7] = m[7] | c0[6];
        m[9] = m[9] | c0[20];
        return m;
    endfunction

    function automatic logic [31:0] register_value(input logic [9:0] idx);
        case (idx)
            lcdc_pkg::REG_CTRL0:   return sh_ctrl[0];
            lcdc_pkg::REG_CTRL1:   return sh_ctrl[1];
            lcdc_pkg::REG_CTRL2:   return sh_ctrl[2];
            lcdc_pkg::REG_CTRL3:   return sh_ctrl[3];
            lcdc_pkg::REG_BRANCH0: return sh_branch0;
            lcdc_pkg::REG_BRANCH1: return sh_branch1;
            lcdc_pkg::REG_STATUS:  return sh_status;
            lcdc_pkg::REG_MISC0:   return sh_misc[0];
            lcdc_pkg::REG_MISC1:   return sh_misc[1];
            lcdc_pkg::REG_MISC2:   return sh_misc[2];
            lcdc_pkg::REG_DESC0:   return sh_desc[0];
            lcdc_pkg::REG_DESC1:   return sh_desc[1];
            lcdc_pkg::REG_DESC2:   return sh_desc[2];
            lcdc_pkg::REG_DESC3:   return sh_desc[3];
            lcdc_pkg::REG_CH1NEXT: return sh_ch1next;
            default:               return '0;
        endcase
    endfunction

    function automatic void store_register(input logic [9:0] idx, input logic [31:0] v);
        case (idx)
            lcdc_pkg::REG_CTRL0:
            begin
                if (sh_ctrl[0][0] != v[0])
                    sh_toggled = 1'b1;
                sh_ctrl[0] = v;
                sh_mask = irq_mask_for(v);
                refresh_irq();
            end
            lcdc_pkg::REG_CTRL1:   sh_ctrl[1] = v;
            lcdc_pkg::REG_CTRL2:   sh_ctrl[2] = v;
            lcdc_pkg::REG_CTRL3:   sh_ctrl[3] = v;
            lcdc_pkg::REG_BRANCH0: sh_branch0 = v;
            lcdc_pkg::REG_BRANCH1: sh_branch1 = v;
            lcdc_pkg::REG_STATUS:
            begin
                sh_status = sh_status & ~v;
                refresh_irq();
            end
            lcdc_pkg::REG_MISC0:   sh_misc[0] = v;
            lcdc_pkg::REG_MISC1:   sh_misc[1] = v;
            lcdc_pkg::REG_MISC2:   sh_misc[2] = v;
            lcdc_pkg::REG_DESC0:   sh_desc[0] = v;
            lcdc_pkg::REG_CH1NEXT: sh_ch1next = v;
            default:               ;
        endcase
    endfunction

    // Advance the shadow by one accepted beat and return the reply it yields
    function automatic lcdc_pkg::lcdc_result_t apply_beat(input lcdc_pkg::lcdc_item_t b);
        lcdc_pkg::lcdc_result_t r;
        r = '0;
        case (b.req_type)
            lcdc_pkg::REQ_READ:
                if (b.word_access)
                    r.read_data = register_value(b.reg_index);
            lcdc_pkg::REQ_WRITE:
                if (b.word_access)
                    store_register(b.reg_index, b.write_data);
            lcdc_pkg::REQ_TICK:
            begin
                // A disable seen at the tick flags status and drops any fetch
                if (sh_toggled)
                begin
                    if (!sh_ctrl[0][0])
                    begin
                        sh_status = sh_status | lcdc_pkg::ST_DISABLED;
                        sh_phase = lcdc_pkg::PH_IDLE;
                    end
                    sh_toggled = 1'b0;
                end
                if (sh_ctrl[0][0])
                begin
                    case (sh_phase)
                        lcdc_pkg::PH_IDLE:
                        begin
                            if (sh_branch0[0])
                            begin
                                sh_branch0[0] = 1'b0;
                                if (sh_branch0[1])
                                    sh_status = sh_status | lcdc_pkg::ST_BRANCH;
                                r.fetch_address = sh_branch0 & lcdc_pkg::DESC_ALIGN;
                            end
                            else
                                r.fetch_address = sh_desc[0];
                            r.fetch_request = 1'b1;
                            sh_phase = lcdc_pkg::PH_WAIT;
                        end
                        lcdc_pkg::PH_SOF:
                        begin
                            if ((sh_desc[3] & lcdc_pkg::CMD_SOF_EN) != 0)
                                sh_status = sh_status | lcdc_pkg::ST_SOF;
                            sh_phase = lcdc_pkg::PH_EOF;
                        end
                        lcdc_pkg::PH_EOF:
                        begin
                            if ((sh_desc[3] & lcdc_pkg::CMD_EOF_EN) != 0)
                                sh_status = sh_status | lcdc_pkg::ST_EOF;
                            sh_phase = lcdc_pkg::PH_IDLE;
                        end
                        default: ;
                    endcase
                end
                refresh_irq();
            end
            lcdc_pkg::REQ_DESC:
                if (sh_phase == lcdc_pkg::PH_WAIT)
                begin
                    sh_desc[0] = b.desc_next;
                    sh_desc[1] = b.desc_source;
                    sh_desc[2] = b.desc_ident;
                    sh_desc[3] = b.desc_command;
                    sh_phase = lcdc_pkg::PH_SOF;
                end
            default: ;
        endcase
        r.irq_level = sh_irq;
        return r;
    endfunction

    function automatic lcdc_pkg::lcdc_item_t make_beat(input lcdc_pkg::lcdc_req_t kind,
                                                       input logic [9:0] idx,
                                                       input logic word,
                                                       input logic [31:0] data);
        lcdc_pkg::lcdc_item_t b;
        b.req_type = kind;
        b.reg_index = idx;
        b.word_access = word;
        b.write_data = data;
        b.desc_next = $urandom;
        b.desc_source = $urandom;
        b.desc_ident = $urandom;
        b.desc_command = $urandom;
        return b;
    endfunction

    function automatic logic [9:0] pick_register();
        case ($urandom_range(17))
            0:  return lcdc_pkg::REG_CTRL0;
            1:  return lcdc_pkg::REG_CTRL1;
            2:  return lcdc_pkg::REG_CTRL2;
            3:  return lcdc_pkg::REG_CTRL3;
            4:  return lcdc_pkg::REG_BRANCH0;
            5:  return lcdc_pkg::REG_BRANCH1;
            6:  return lcdc_pkg::REG_STATUS;
            7:  return lcdc_pkg::REG_MISC0;
            8:  return lcdc_pkg::REG_MISC1;
            9:  return lcdc_pkg::REG_MISC2;
            10: return lcdc_pkg::REG_DESC0;
            11: return lcdc_pkg::REG_DESC1;
            12: return lcdc_pkg::REG_DESC2;
            13: return lcdc_pkg::REG_DESC3;
            14: return lcdc_pkg::REG_CH1NEXT;
            15: return REG_UNMAPPED_LO;
            16: return REG_UNMAPPED_HI;
            default: return lcdc_pkg::REG_STATUS;
        endcase
    endfunction

    // Present one beat, hold it until accepted, then predict its reply.
    // Entered and left at a falling edge.
    task automatic send_beat(input lcdc_pkg::lcdc_item_t b);
        logic taken;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= b.req_type;
        reg_index <= b.reg_index;
        word_access <= b.word_access;
        write_data <= b.write_data;
        desc_next <= b.desc_next;
        desc_source <= b.desc_source;
        desc_ident <= b.desc_ident;
        desc_command <= b.desc_command;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
        end
        reply_q.push_back(apply_beat(b));
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic bus_read(input logic [9:0] idx, input logic word);
        send_beat(make_beat(lcdc_pkg::REQ_READ, idx, word, $urandom));
    endtask

    task automatic bus_write(input logic [9:0] idx, input logic [31:0] data, input logic word);
        send_beat(make_beat(lcdc_pkg::REQ_WRITE, idx, word, data));
    endtask

    task automatic frame_tick();
        send_beat(make_beat(lcdc_pkg::REQ_TICK, pick_register(),
                            1'($urandom_range(1)), $urandom));
    endtask

    task automatic return_desc(input logic [31:0] nxt, input logic [31:0] src,
                               input logic [31:0] ident, input logic [31:0] cmd);
        lcdc_pkg::lcdc_item_t b;
        b = make_beat(lcdc_pkg::REQ_DESC, pick_register(), 1'($urandom_range(1)), $urandom);
        b.desc_next = nxt;
        b.desc_source = src;
        b.desc_ident = ident;
        b.desc_command = cmd;
        send_beat(b);
    endtask

    // Read-back of writable, read-only, unmapped and non-word accesses
    task automatic test_register_map();
        bus_write(lcdc_pkg::REG_CTRL1, 32'hFFFF_FFFF, 1'b1);
        bus_read(lcdc_pkg::REG_CTRL1, 1'b1);
        bus_write(lcdc_pkg::REG_MISC2, 32'hFFFF_FFFF, 1'b1);
        bus_read(lcdc_pkg::REG_MISC2, 1'b1);
        bus_write(lcdc_pkg::REG_DESC1, 32'hFFFF_FFFF, 1'b1);
        bus_read(lcdc_pkg::REG_DESC1, 1'b1);
        bus_write(REG_LAST, 32'hFFFF_FFFF, 1'b1);
        bus_read(REG_LAST, 1'b1);
        bus_write(lcdc_pkg::REG_CTRL2, 32'h1234_5678, 1'b0);
        bus_read(lcdc_pkg::REG_CTRL2, 1'b0);
        bus_read(lcdc_pkg::REG_CTRL2, 1'b1);
    endtask

    // Walk fetch, start and end of frame, then branch and disable
    task automatic test_frame_sequence();
        bus_write(lcdc_pkg::REG_CTRL0, CTRL_ALL_IRQ | CTRL_ENABLE, 1'b1);
        bus_write(lcdc_pkg::REG_DESC0, 32'h0000_1000, 1'b1);
        frame_tick();
        frame_tick();
        return_desc(32'h0000_2000, 32'hFFFF_FFFF, 32'h0,
                    lcdc_pkg::CMD_SOF_EN | lcdc_pkg::CMD_EOF_EN);
        frame_tick();
        frame_tick();
        return_desc(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        bus_write(lcdc_pkg::REG_BRANCH0, 32'hFFFF_FFFF, 1'b1);
        frame_tick();
        bus_write(lcdc_pkg::REG_CTRL0, 32'h0, 1'b1);
        frame_tick();
        frame_tick();
        bus_read(lcdc_pkg::REG_STATUS, 1'b1);
        bus_write(lcdc_pkg::REG_STATUS, 32'hFFFF_FFFF, 1'b1);
        bus_read(lcdc_pkg::REG_STATUS, 1'b1);
    endtask

    // One full frame with random descriptor content, optionally via a branch
    task automatic random_frame_walk();
        if (!sh_ctrl[0][0])
            bus_write(lcdc_pkg::REG_CTRL0, $urandom | CTRL_ENABLE, 1'b1);
        if ($urandom_range(3) == 0)
            bus_write(lcdc_pkg::REG_BRANCH0, $urandom | 32'h1, 1'b1);
        frame_tick();
        if ($urandom_range(7) == 0)
            frame_tick();
        return_desc($urandom, $urandom, $urandom, $urandom);
        frame_tick();
        frame_tick();
        if ($urandom_range(1))
            bus_read(lcdc_pkg::REG_STATUS, 1'b1);
        if ($urandom_range(2) == 0)
            bus_write(lcdc_pkg::REG_STATUS, $urandom, 1'b1);
    endtask

    task automatic test_random_traffic(input int count);
        int target;
        int pick;
        lcdc_pkg::lcdc_item_t b;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                random_frame_walk();
            else if (pick < 57)
                bus_write(pick_register(), $urandom, 1'b1);
            else if (pick < 80)
                bus_read(pick_register(), 1'b1);
            else if (pick < 88)
            begin
                // Drop in a fully random beat
                b = make_beat(lcdc_pkg::lcdc_req_t'($urandom_range(3)),
                              10'($urandom_range(1023)),
                              1'($urandom_range(1)), $urandom);
                send_beat(b);
            end
            else if (pick < 94)
            begin
                if ($urandom_range(1))
                    frame_tick();
                else
                    return_desc($urandom, $urandom, $urandom, $urandom);
            end
            else
                bus_write(lcdc_pkg::REG_CTRL0, $urandom, 1'b1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = lcdc_pkg::REQ_READ;
        reg_index = '0;
        word_access = 1'b0;
        write_data = '0;
        desc_next = '0;
        desc_source = '0;
        desc_ident = '0;
        desc_command = '0;
        beats_sent = 0;
        sender_idle_pct = 38;
        receiver_idle_pct = 66;
        clear_shadow();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_map();
        test_frame_sequence();
        test_random_traffic(RANDOM_BEATS);
        sender_idle_pct = 66;
        receiver_idle_pct = 38;
        test_random_traffic(RANDOM_BEATS);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random_traffic(RANDOM_BEATS);
        in_valid <= 1'b0;

        // Drain outstanding replies, then watch for strays
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
